>>> hw/rtl/q8bu_pkg.sv
// q8bu_pkg: shared constants and types for the quantized block unpacker.
// Half-float field constants, register reset value and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package q8bu_pkg;

    // Parameter defaults
    localparam int BLOCK_WEIGHTS_DEFAULT = 32;
    localparam int COUNT_BITS_DEFAULT    = 32;

    // Configuration register
    localparam int               WEIGHT_COUNT_W     = 32;
    localparam logic [31:0]      WEIGHT_COUNT_RESET = 32'd32;

    // Half-precision fields
    localparam int               HALF_MAN_W  = 10;
    localparam logic [4:0]       HALF_EXP_ONES = 5'h1f;
    localparam logic [7:0]       EXP_BIAS_ADJ  = 8'd112;  // 127 - 15
    localparam logic [7:0]       SUBN_EXP_BASE = 8'd103;  // 113 - 10

    typedef struct packed {
        logic [31:0]        scale_bits;
        logic signed [7:0]  weight;
        logic               last_in_block;
        logic               last_in_tensor;
    } q8bu_result_t;

endpackage : q8bu_pkg

`default_nettype wire

>>> hw/rtl/q8_block_unpacker.sv
// q8_block_unpacker: weight bytes pass combinationally into the result register,
// or into the skid entry while that is held. Throughput: one byte per cycle
// while the skid is empty; the scale conversion feeds the scale register.
// A two-entry output stage (result register plus skid) keeps s_tready high
// while one result waits on m_tready.
// Reset (rst_n, async, active low): position/count/scale clear, weight_count=32.
`timescale 1ns / 1ps
`default_nettype none

module q8_block_unpacker
    import q8bu_pkg::*;
#(
    parameter int BLOCK_WEIGHTS = BLOCK_WEIGHTS_DEFAULT,  // 1..256
    parameter int COUNT_BITS    = COUNT_BITS_DEFAULT      // 8..64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration: weight_count
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,

    // byte stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] raw_byte

    // weight stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] weight, [39:8] scale_bits
    output logic             m_tlast,   // last_in_tensor
    output logic [0:0]       m_tuser    // [0] last_in_block
);

    // Block layout: two scale bytes, then BLOCK_WEIGHTS weight bytes.
    localparam int BLOCK_BYTES = BLOCK_WEIGHTS + 2;
    localparam int POS_W       = $clog2(BLOCK_BYTES);
    localparam logic [POS_W-1:0] POS_SCALE_LO = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SCALE_HI = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(BLOCK_BYTES - 1);
    // compare width: covers the counter, the register, and counter + 1
    localparam int CMP_W = ((COUNT_BITS > WEIGHT_COUNT_W) ? COUNT_BITS : WEIGHT_COUNT_W) + 1;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [POS_W-1:0]          pos_reg,          pos_next;
    logic [7:0]                scale_lo_reg;
    logic [31:0]               scale_word_reg;
    logic [COUNT_BITS-1:0]     wdone_reg,        wdone_next;
    logic [WEIGHT_COUNT_W-1:0] wcount_reg;

    // output stage: result register plus one skid entry
    q8bu_result_t              out_reg,  skid_reg;
    logic                      out_valid_reg, skid_valid_reg;

    logic                      in_xact;
    logic                      out_pop;
    logic                      is_weight_byte;
    logic                      block_end;
    logic                      emit;
    logic                      end_tensor;
    logic [CMP_W-1:0]          wdone_ext;
    logic [CMP_W-1:0]          wcount_ext;
    logic [COUNT_BITS-1:0]     wdone_inc;
    logic [COUNT_BITS-1:0]     wdone_after;
    logic [31:0]               scale_conv;
    q8bu_result_t              res_new;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_xact   = s_tvalid && s_tready;
    assign out_pop   = out_valid_reg && m_tready;

    // ------------------------------------------------------------------
    // Byte decode
    // ------------------------------------------------------------------
    q8bu_half_to_single u_cvt (
        .half_bits   ({s_tdata, scale_lo_reg}),
        .single_bits (scale_conv)
    );

    assign is_weight_byte = (pos_reg != POS_SCALE_LO) && (pos_reg != POS_SCALE_HI);
    assign block_end      = (pos_reg == POS_LAST);

    assign wdone_ext  = CMP_W'(wdone_reg);
    assign wcount_ext = CMP_W'(wcount_reg);

    // a weight byte emits only while the tensor still has weights left
    assign emit       = is_weight_byte && (wdone_ext < wcount_ext);
    assign end_tensor = (wdone_ext + CMP_W'(1)) == wcount_ext;

    assign wdone_inc   = wdone_reg + COUNT_BITS'(1);
    assign wdone_after = emit ? wdone_inc : wdone_reg;

    always_comb
    begin
        pos_next   = block_end ? '0 : pos_reg + POS_W'(1);
        wdone_next = wdone_after;
        // tensor closes at the end of the block holding the last weight
        if (block_end && (CMP_W'(wdone_after) >= wcount_ext))
        begin
            wdone_next = '0;
        end
    end

    always_comb
    begin
        res_new.weight         = $signed(s_tdata);
        res_new.scale_bits     = scale_word_reg;
        res_new.last_in_tensor = end_tensor;
        res_new.last_in_block  = end_tensor || block_end;
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            scale_lo_reg   <= '0;
            scale_word_reg <= '0;
            wdone_reg      <= '0;
            wcount_reg     <= WEIGHT_COUNT_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                wcount_reg <= cfg_data;
            end
            if (in_xact)
            begin
                pos_reg   <= pos_next;
                wdone_reg <= wdone_next;
                if (pos_reg == POS_SCALE_LO)
                begin
                    scale_lo_reg <= s_tdata;
                end
                if (pos_reg == POS_SCALE_HI)
                begin
                    scale_word_reg <= scale_conv;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: skid only fills when the result register is held
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_pop && skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (in_xact && emit && (!out_valid_reg || out_pop))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (in_xact && emit)
            begin
                skid_valid_reg <= 1'b1;
            end
            else if (out_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (in_xact && emit && (!out_valid_reg || out_pop))
        begin
            out_reg <= res_new;
        end
        else if (in_xact && emit)
        begin
            skid_reg <= res_new;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_reg.scale_bits, out_reg.weight};
    assign m_tlast    = out_reg.last_in_tensor;
    assign m_tuser[0] = out_reg.last_in_block;

endmodule : q8_block_unpacker

`default_nettype wire

>>> hw/rtl/q8bu_half_to_single.sv
// q8bu_half_to_single: combinational half-float to single-float bit pattern.
// All-ones exponent and zero of either sign map to +0; subnormals normalized.
// Depends on q8bu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module q8bu_half_to_single
    import q8bu_pkg::*;
(
    input  wire logic [15:0] half_bits,
    output logic      [31:0] single_bits
);

    logic [4:0]            h_exp;
    logic [HALF_MAN_W-1:0] h_man;
    logic [3:0]            msb_idx;
    logic [3:0]            shamt;
    logic [HALF_MAN_W:0]   man_shift;
    logic [7:0]            f_exp;
    logic [HALF_MAN_W-1:0] f_man;

    assign h_exp = half_bits[14:10];
    assign h_man = half_bits[HALF_MAN_W-1:0];

    // highest set mantissa bit
    always_comb
    begin
        msb_idx = '0;
        for (int i = 0; i < HALF_MAN_W; i++)
        begin
            if (h_man[i])
            begin
                msb_idx = 4'(i);
            end
        end
    end

    assign shamt     = 4'(HALF_MAN_W) - msb_idx;
    assign man_shift = {1'b0, h_man} << shamt;

    always_comb
    begin
        if (h_exp == '0)
        begin
            f_exp = SUBN_EXP_BASE + {4'd0, msb_idx};
            f_man = man_shift[HALF_MAN_W-1:0];
        end
        else
        begin
            f_exp = {3'd0, h_exp} + EXP_BIAS_ADJ;
            f_man = h_man;
        end
    end

    always_comb
    begin
        if (h_exp == HALF_EXP_ONES || (h_exp == '0 && h_man == '0))
        begin
            single_bits = '0;
        end
        else
        begin
            single_bits = {half_bits[15], f_exp, f_man, 13'd0};
        end
    end

endmodule : q8bu_half_to_single

`default_nettype wire

>>> verif/q8_block_unpacker_tb.sv
// q8_block_unpacker_tb: self-checking testbench for the quantized block unpacker.
// Sends 34-byte blocks, predicts every weight transaction and checks it field by field.
// Depends on q8bu_pkg and q8_block_unpacker.
`timescale 1ns / 1ps

module q8_block_unpacker_tb;
    import q8bu_pkg::*;

    // One block: two scale bytes, then one byte per weight
    localparam int BLOCK_BYTES = BLOCK_WEIGHTS_DEFAULT + 2;
    // Cycles to let the output stage settle after the last expected result
    localparam int SETTLE_CYCLES = 4;
    // Watchdog: cycles with no transaction on any channel
    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] raw_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [7:0] weight, [39:8] scale_bits
    logic        m_tlast;    // last_in_tensor
    logic [0:0]  m_tuser;    // [0] last_in_block

    q8_block_unpacker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------
    // Shadow of the unpacker state, updated on every accepted byte
    // ------------------------------------------------------------------
    int          blk_pos;      // byte index inside the current block
    logic [7:0]  scale_lo;     // first scale byte, held for the second
    logic [31:0] cur_scale;    // widened scale of the current block
    logic [31:0] emitted;      // weights emitted in the current tensor
    logic [31:0] tensor_len;   // shadow of the weight_count register

    q8bu_result_t expected_weights[$];

    // Traffic shaping, percent of cycles
    int send_idle_pct;
    int recv_stall_pct;

    // Run statistics
    int err_count;
    int n_bytes;
    int n_results;
    int blocks_sent;
    int n_cfg;

    // Half to single-float bit pattern. Exponent all ones is forced to zero,
    // signed zero gives +0, subnormals are shifted up to a hidden one.
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0]  ex;
        logic [10:0] man;
        logic [7:0]  fex;
        int          sh;
        ex  = h[14:10];
        man = {1'b0, h[9:0]};
        sh  = 0;
        if (ex == HALF_EXP_ONES)
            return 32'd0;
        if (ex == 5'd0)
        begin
            if (man == 11'd0)
                return 32'd0;
            while (!man[HALF_MAN_W])
            begin
                man = man << 1;
                sh++;
            end
            // smallest normal half exponent rebiased, minus the shift
            fex = EXP_BIAS_ADJ + 8'd1 - 8'(sh);
        end
        else
        begin
            fex = EXP_BIAS_ADJ + 8'(ex);
        end
        return {h[15], fex, man[9:0], 13'd0};
    endfunction

    // Advance the shadow by one accepted byte; queue a weight if one results
    function automatic void unpack_byte(input logic [7:0] b);
        logic [32:0]  next_cnt;
        q8bu_result_t r;
        if (blk_pos == 0)
        begin
            scale_lo = b;
        end
        else if (blk_pos == 1)
        begin
            cur_scale = widen_half({b, scale_lo});
        end
        else if (emitted < tensor_len)
        begin
            next_cnt         = {1'b0, emitted} + 33'd1;
            r.weight         = b;
            r.scale_bits     = cur_scale;
            r.last_in_tensor = (next_cnt == {1'b0, tensor_len});
            r.last_in_block  = r.last_in_tensor || (blk_pos == BLOCK_BYTES - 1);
            expected_weights.push_back(r);
            emitted = emitted + 32'd1;
        end
        // padding bytes still count toward the block end
        if (blk_pos + 1 >= BLOCK_BYTES)
        begin
            blk_pos = 0;
            if (emitted >= tensor_len)
                emitted = 32'd0;
        end
        else
        begin
            blk_pos++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, receiver, checker, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls on m_tready, per the current idle phase
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every weight transaction is matched against the oldest prediction
    always @(posedge clk)
    begin : weight_check
        q8bu_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_weights.size() == 0)
            begin
                $error("unexpected weight transaction: weight %0d scale 0x%08h",
                       $signed(m_tdata[7:0]), m_tdata[39:8]);
                err_count++;
            end
            else
            begin
                want = expected_weights.pop_front();
                n_results++;
                if (m_tdata[7:0] !== want.weight)
                begin
                    $error("weight: expected %0d, got %0d",
                           want.weight, $signed(m_tdata[7:0]));
                    err_count++;
                end
                if (m_tdata[39:8] !== want.scale_bits)
                begin
                    $error("scale_bits: expected 0x%08h, got 0x%08h",
                           want.scale_bits, m_tdata[39:8]);
                    err_count++;
                end
                if (m_tuser[0] !== want.last_in_block)
                begin
                    $error("last_in_block: expected %0b, got %0b",
                           want.last_in_block, m_tuser[0]);
                    err_count++;
                end
                if (m_tlast !== want.last_in_tensor)
                begin
                    $error("last_in_tensor: expected %0b, got %0b",
                           want.last_in_tensor, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: quiet cycles on all three channels end the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("timeout: %0d cycles without a transaction, %0d results pending",
                         quiet, expected_weights.size());
                $display("q8_block_unpacker_tb: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers; all called at a rising edge
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        unpack_byte(b);
        n_bytes++;
    endtask

    // Hold the stream until every predicted weight has come out, then let
    // the output stage settle (padding bytes may still be in flight)
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_weights.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_weight_count(input logic [31:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        tensor_len = value;
        n_cfg++;
    endtask

    // One block. extremes picks weights from the corners of the byte range;
    // pause_at >= 0 drains all results after byte pause_at of the block.
    task automatic send_block(input logic [15:0] scale, input bit extremes,
                              input int pause_at);
        logic [7:0] corner[6];
        logic [7:0] b;
        corner = '{8'h00, 8'h7f, 8'h80, 8'hff, 8'h01, 8'hfe};
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            if (i == 0)
                b = scale[7:0];
            else if (i == 1)
                b = scale[15:8];
            else if (extremes)
                b = corner[(i - 2) % 6];
            else
                b = 8'($urandom_range(255));
            send_byte(b);
            if (i == pause_at)
                drain_results();
        end
        blocks_sent++;
    endtask

    // Random scale, weighted toward zeros, forced-zero and subnormal codes
    function automatic logic [15:0] pick_scale();
        logic [15:0] h;
        h = 16'($urandom);
        case ($urandom_range(7))
            0: h = {h[15], 15'd0};
            1: h[14:10] = HALF_EXP_ONES;
            2: h[14:10] = 5'd0;
            default: ;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(5))
            0: return 32'd1;
            1: return 32'(BLOCK_WEIGHTS_DEFAULT * $urandom_range(1, 4));
            2: return 32'($urandom_range(1, 200));
            3: return 32'($urandom_range(1, BLOCK_WEIGHTS_DEFAULT - 1));
            4: return 32'(BLOCK_WEIGHTS_DEFAULT * $urandom_range(1, 3)
                          + $urandom_range(1, BLOCK_WEIGHTS_DEFAULT - 1));
            default: return $urandom;   // usually too large to end in this run
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset value of weight_count: one block is exactly one tensor
    task automatic test_reset_count();
        send_block(16'h3c00, 1'b1, -1);
        send_block(16'hbc00, 1'b1, -1);
    endtask

    // Scale widening: zeros of both signs, infinities and NaNs forced to zero,
    // smallest and largest subnormals, smallest and largest normals
    task automatic test_scale_widening();
        logic [15:0] scales[10];
        scales = '{16'h0000, 16'h8000, 16'h7c00, 16'hfc00, 16'h7e01,
                   16'h0001, 16'h83ff, 16'h0200, 16'h0400, 16'h7bff};
        write_weight_count(32'(BLOCK_WEIGHTS_DEFAULT * 10));
        foreach (scales[i])
            send_block(scales[i], 1'b1, -1);
    endtask

    // Tensor ends inside a block, padding dropped, tensor spanning blocks,
    // single weight, and a zero count that never emits
    task automatic test_tensor_end();
        write_weight_count(32'd5);
        send_block(16'h4000, 1'b1, -1);
        send_block(16'hc200, 1'b0, -1);
        write_weight_count(32'(BLOCK_WEIGHTS_DEFAULT + 1));
        send_block(16'h3555, 1'b0, -1);
        send_block(16'h2aaa, 1'b0, -1);
        write_weight_count(32'd1);
        send_block(16'h5140, 1'b1, -1);
        write_weight_count(32'd0);
        send_block(16'h3c00, 1'b1, -1);
    endtask

    // Largest count: tensor never ends here; then a smaller count lands
    // below the running total, so the next block is all padding
    task automatic test_max_count();
        write_weight_count(32'hffff_ffff);
        send_block(16'h1234, 1'b0, -1);
        send_block(16'h8765, 1'b0, -1);
        write_weight_count(32'(BLOCK_WEIGHTS_DEFAULT));
        send_block(16'h4321, 1'b0, -1);
        send_block(16'h4400, 1'b0, -1);
    endtask

    // Sender holds mid-block until the output is empty, then resumes
    task automatic test_drain_pause();
        write_weight_count(32'd40);
        recv_stall_pct = 45;
        send_block(16'h3800, 1'b0, 12);
        send_block(16'h0123, 1'b0, 2 + $urandom_range(7));
        recv_stall_pct = 0;
    endtask

    // Random blocks over the four idle phases, two counts per phase
    task automatic test_random_traffic();
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 45, 0, 18};
        recv_pct = '{0, 0, 45, 18};
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            for (int run = 0; run < 2; run++)
            begin
                write_weight_count(pick_count());
                for (int k = 0; k < 3; k++)
                    send_block(pick_scale(), ($urandom_range(9) == 0), -1);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_data       <= 32'd0;
        s_tvalid       <= 1'b0;
        s_tdata        <= 8'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        err_count      = 0;
        n_bytes        = 0;
        n_results      = 0;
        blocks_sent    = 0;
        n_cfg          = 0;
        blk_pos        = 0;
        scale_lo       = 8'd0;
        cur_scale      = 32'd0;
        emitted        = 32'd0;
        tensor_len     = WEIGHT_COUNT_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_count();
        test_scale_widening();
        test_tensor_end();
        test_max_count();
        test_drain_pause();
        test_random_traffic();

        drain_results();
        repeat (16) @(posedge clk);

        $display("covered %0d bytes in %0d blocks, %0d weights checked, %0d count writes",
                 n_bytes, blocks_sent, n_results, n_cfg);
        $display("scale corner codes, padding, tensor ends, mid-block drain, four idle phases");
        if (err_count == 0)
            $display("q8_block_unpacker_tb: done, clean");
        else
            $display("q8_block_unpacker_tb: done, errors");
        $finish;
    end

endmodule
